>>> rtl/mtd_pkg.sv
// ----------------------------------------------------------------------------
// MIDI track event decoder package
// Shared types and constants for the track parser.
// ----------------------------------------------------------------------------
package mtd_pkg;

  localparam int TICK_BITS    = 32;
  localparam int NUM_CHANNELS = 16;
  localparam int NUM_KEYS     = 128;
  localparam int VLQ_BITS     = 28;
  localparam int NOTE_DEPTH   = NUM_KEYS * NUM_CHANNELS;
  localparam int NOTE_AW      = $clog2(NOTE_DEPTH);
  // note entry: sounding flag, velocity, start tick
  localparam int NOTE_W       = 1 + 7 + TICK_BITS;

  localparam logic [1:0] KIND_NOTE  = 2'd0;
  localparam logic [1:0] KIND_PEDAL = 2'd1;
  localparam logic [1:0] KIND_TEMPO = 2'd2;

  localparam logic [7:0] CC_SUSTAIN  = 8'h40;
  localparam logic [7:0] META_TEMPO  = 8'h51;
  localparam logic [7:0] ST_META     = 8'hFF;
  localparam logic [7:0] ST_SYSEX    = 8'hF0;
  localparam logic [7:0] ST_EOX      = 8'hF7;
  localparam logic [7:0] ST_MTC      = 8'hF1;
  localparam logic [7:0] ST_SONG_POS = 8'hF2;
  localparam logic [7:0] ST_SONG_SEL = 8'hF3;

  localparam logic [3:0] SN_NOTE_OFF = 4'h8;
  localparam logic [3:0] SN_NOTE_ON  = 4'h9;
  localparam logic [3:0] SN_CTRL     = 4'hB;
  localparam logic [3:0] SN_PROG     = 4'hC;
  localparam logic [3:0] SN_PRESS    = 4'hD;
  localparam logic [3:0] SN_PITCH    = 4'hE;
  localparam logic [3:0] SN_SYS      = 4'hF;

  typedef enum logic [3:0] {
    PH_DELTA,
    PH_STATUS,
    PH_DATA1,
    PH_DATA2,
    PH_SKIP,
    PH_META_TYPE,
    PH_META_LEN,
    PH_TEMPO_A,
    PH_TEMPO_B,
    PH_TEMPO_C,
    PH_SYSEX
  } phase_t;

  typedef struct packed {
    logic [1:0]           record_kind;
    logic [3:0]           channel;
    logic [6:0]           key;
    logic [6:0]           value;
    logic [TICK_BITS-1:0] start_tick;
    logic [TICK_BITS-1:0] stop_tick;
    logic [23:0]          tempo;
  } record_t;

endpackage

>>> rtl/mtd_if.sv
// ----------------------------------------------------------------------------
// MIDI track decoder channels
// Byte input channel and record output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface mtd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] track_byte;
  logic       track_start;
  modport source (output valid, output track_byte, output track_start, input ready);
  modport sink   (input valid, input track_byte, input track_start, output ready);
endinterface

interface mtd_rec_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    record_kind;
  logic [3:0]                    channel;
  logic [6:0]                    key;
  logic [6:0]                    value;
  logic [mtd_pkg::TICK_BITS-1:0] start_tick;
  logic [mtd_pkg::TICK_BITS-1:0] stop_tick;
  logic [23:0]                   tempo;
  modport source (output valid, output record_kind, output channel, output key,
                  output value, output start_tick, output stop_tick, output tempo,
                  input ready);
  modport sink   (input valid, input record_kind, input channel, input key,
                  input value, input start_tick, input stop_tick, input tempo,
                  output ready);
endinterface

>>> rtl/mtd_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mtd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/midi_track_event_decoder.sv
// ----------------------------------------------------------------------------
// MIDI track event decoder
// Parses track chunk bytes into note, sustain pedal and tempo records.
// ----------------------------------------------------------------------------
// Usage:
//   byte_in takes one word per track byte; track_start marks the first byte
//   of a track (tick cleared, parser back at delta time).
//   rec_out gives one record word for a finished note, a sustain pedal span
//   or a tempo change.
// Throughput: one byte per cycle while a queue slot is free; byte_in waits
//   after the second data byte of a note-on or note-off: the note table
//   entry, read from the synchronous RAM at accept, is written back next cycle.
// Record timing: tempo and pedal records enter the output queue at the accept
//   edge, note records in the cycle after it; the queue head is the port.
// Reset: parser state clears at once; the note table is then swept to
//   "not sounding", one entry a cycle, all 2048, with byte_in held not ready.
// Stall: a two-word output queue holds records while rec_out is stalled;
//   byte_in is ready while one slot is free, but not during sweep or write-back.
// ----------------------------------------------------------------------------
module midi_track_event_decoder (
  input logic         clk,
  input logic         rst,
  mtd_byte_if.sink    byte_in,
  mtd_rec_if.source   rec_out
);

  localparam int TB = mtd_pkg::TICK_BITS;
  localparam int VB = mtd_pkg::VLQ_BITS;
  localparam int AW = mtd_pkg::NOTE_AW;

  // parser registers
  mtd_pkg::phase_t phase, phase_next;
  logic [3:0]      run_status, run_status_next;
  logic [3:0]      run_ch, run_ch_next;
  logic [15:0]     held, held_next;
  logic [VB-1:0]   delta_acc, delta_acc_next;
  logic [TB-1:0]   tick, tick_next;
  logic [VB-1:0]   skip, skip_next;

  // pedal table, small enough for flops
  logic [mtd_pkg::NUM_CHANNELS-1:0] ped_on;
  logic [TB-1:0]                    ped_start [mtd_pkg::NUM_CHANNELS];
  logic                             ped_we;
  logic                             ped_on_next;

  // note table sweep
  logic          clr;
  logic [AW-1:0] clr_addr;

  // note read-modify-write
  logic          busy;
  logic [AW-1:0] nt_addr;
  logic          nt_is_on;
  logic [6:0]    nt_vel;
  logic          note_op;
  logic [mtd_pkg::NOTE_W-1:0] nt_rdata;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [mtd_pkg::NOTE_W-1:0] ram_wdata;

  // effective state after track_start
  mtd_pkg::phase_t ph_e;
  logic [TB-1:0]   tick_e;
  logic [VB-1:0]   dacc_e, skip_e;
  logic [15:0]     held_e;
  logic [7:0]      b;
  logic            accept;

  // output queue
  mtd_pkg::record_t q0, q1, push_rec, parse_rec, note_rec;
  logic [1:0]       q_cnt;
  logic             push, pop, parse_emit, note_emit;

  assign accept = byte_in.valid && byte_in.ready;
  assign byte_in.ready = !clr && !busy && (q_cnt != 2'd2);
  assign b = byte_in.track_byte;

  always_comb begin
    ph_e   = phase;
    tick_e = tick;
    dacc_e = delta_acc;
    skip_e = skip;
    held_e = held;
    if (byte_in.track_start) begin
      ph_e   = mtd_pkg::PH_DELTA;
      tick_e = '0;
      dacc_e = '0;
      skip_e = '0;
      held_e = '0;
    end
  end

  // parser next state
  always_comb begin
    logic [VB-1:0] vlq;
    logic [TB:0]   sum;
    logic          do_delta;
    logic          do_first;
    logic [VB-1:0] dec;
    vlq             = {dacc_e[VB-8:0], b[6:0]};
    sum             = {1'b0, tick_e} + {{(TB+1-VB){1'b0}}, vlq};
    dec             = skip_e - 1'b1;
    do_delta        = 1'b0;
    do_first        = 1'b0;
    phase_next      = ph_e;
    run_status_next = run_status;
    run_ch_next     = run_ch;
    held_next       = held_e;
    delta_acc_next  = dacc_e;
    tick_next       = tick_e;
    skip_next       = skip_e;
    note_op         = 1'b0;
    ped_we          = 1'b0;
    ped_on_next     = 1'b0;
    case (ph_e)
      mtd_pkg::PH_DELTA: do_delta = 1'b1;
      mtd_pkg::PH_STATUS: begin
        if (!b[7]) begin
          if (run_status inside {[mtd_pkg::SN_NOTE_OFF:mtd_pkg::SN_PITCH]}) begin
            do_first = 1'b1;
          end else begin
            do_delta = 1'b1;
          end
        end else begin
          run_status_next = b[7:4];
          if (b[7:4] != mtd_pkg::SN_SYS) begin
            run_ch_next = b[3:0];
            phase_next  = mtd_pkg::PH_DATA1;
          end else if (b == mtd_pkg::ST_META) begin
            phase_next = mtd_pkg::PH_META_TYPE;
          end else if (b == mtd_pkg::ST_SYSEX) begin
            phase_next = mtd_pkg::PH_SYSEX;
          end else if (b == mtd_pkg::ST_MTC || b == mtd_pkg::ST_SONG_SEL) begin
            skip_next  = VB'(1);
            phase_next = mtd_pkg::PH_SKIP;
          end else if (b == mtd_pkg::ST_SONG_POS) begin
            skip_next  = VB'(2);
            phase_next = mtd_pkg::PH_SKIP;
          end else begin
            phase_next = mtd_pkg::PH_DELTA;
          end
        end
      end
      mtd_pkg::PH_DATA1: do_first = 1'b1;
      mtd_pkg::PH_DATA2: begin
        phase_next = mtd_pkg::PH_DELTA;
        if (run_status == mtd_pkg::SN_NOTE_OFF || run_status == mtd_pkg::SN_NOTE_ON) begin
          note_op = 1'b1;
        end else if (run_status == mtd_pkg::SN_CTRL &&
                     held_e[6:0] == mtd_pkg::CC_SUSTAIN[6:0]) begin
          ped_we      = 1'b1;
          ped_on_next = !ped_on[run_ch] || (b[6:0] != 7'd0);
        end
      end
      mtd_pkg::PH_SKIP: begin
        skip_next = dec;
        if (dec == '0) phase_next = mtd_pkg::PH_DELTA;
      end
      mtd_pkg::PH_META_TYPE: begin
        held_next  = {8'd0, b};
        skip_next  = '0;
        phase_next = mtd_pkg::PH_META_LEN;
      end
      mtd_pkg::PH_META_LEN: begin
        skip_next = {skip_e[VB-8:0], b[6:0]};
        if (!b[7]) begin
          if ({skip_e[VB-8:0], b[6:0]} == '0) begin
            phase_next = mtd_pkg::PH_DELTA;
          end else if (held_e[7:0] == mtd_pkg::META_TEMPO) begin
            phase_next = mtd_pkg::PH_TEMPO_A;
          end else begin
            phase_next = mtd_pkg::PH_SKIP;
          end
          held_next = '0;
        end
      end
      mtd_pkg::PH_TEMPO_A, mtd_pkg::PH_TEMPO_B: begin
        held_next  = {held_e[7:0], b};
        phase_next = (ph_e == mtd_pkg::PH_TEMPO_A) ? mtd_pkg::PH_TEMPO_B
                                                   : mtd_pkg::PH_TEMPO_C;
        skip_next  = dec;
        if (dec == '0) phase_next = mtd_pkg::PH_DELTA;
      end
      mtd_pkg::PH_TEMPO_C: begin
        phase_next = mtd_pkg::PH_SKIP;
        skip_next  = dec;
        if (dec == '0) phase_next = mtd_pkg::PH_DELTA;
      end
      mtd_pkg::PH_SYSEX: begin
        if (b == mtd_pkg::ST_EOX) phase_next = mtd_pkg::PH_DELTA;
      end
      default: do_delta = 1'b1;
    endcase
    if (do_first) begin
      if (run_status == mtd_pkg::SN_PROG || run_status == mtd_pkg::SN_PRESS) begin
        phase_next = mtd_pkg::PH_DELTA;
      end else begin
        held_next  = {9'd0, b[6:0]};
        phase_next = mtd_pkg::PH_DATA2;
      end
    end
    if (do_delta) begin
      if (b[7]) begin
        delta_acc_next = vlq;
      end else begin
        tick_next      = sum[TB] ? '1 : sum[TB-1:0];
        delta_acc_next = '0;
        phase_next     = mtd_pkg::PH_STATUS;
      end
    end
  end

  // parser record output
  always_comb begin
    parse_emit = 1'b0;
    parse_rec  = '0;
    case (ph_e)
      mtd_pkg::PH_TEMPO_C: begin
        parse_emit           = 1'b1;
        parse_rec.record_kind = mtd_pkg::KIND_TEMPO;
        parse_rec.start_tick = tick_e;
        parse_rec.tempo      = {held_e, b};
      end
      mtd_pkg::PH_DATA2: begin
        if (run_status == mtd_pkg::SN_CTRL &&
            held_e[6:0] == mtd_pkg::CC_SUSTAIN[6:0] && ped_on[run_ch]) begin
          parse_emit            = 1'b1;
          parse_rec.record_kind = mtd_pkg::KIND_PEDAL;
          parse_rec.channel     = run_ch;
          parse_rec.value       = b[6:0];
          parse_rec.start_tick  = ped_start[run_ch];
          parse_rec.stop_tick   = tick_e;
        end
      end
      default: parse_emit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= mtd_pkg::PH_DELTA;
      run_status <= '0;
      run_ch     <= '0;
      held       <= '0;
      delta_acc  <= '0;
      tick       <= '0;
      skip       <= '0;
      ped_on     <= '0;
    end else if (accept) begin
      phase      <= phase_next;
      run_status <= run_status_next;
      run_ch     <= run_ch_next;
      held       <= held_next;
      delta_acc  <= delta_acc_next;
      tick       <= tick_next;
      skip       <= skip_next;
      if (ped_we) ped_on[run_ch] <= ped_on_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && ped_we) ped_start[run_ch] <= tick_e;
  end

  // note table: read at accept, write back next cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      clr      <= 1'b1;
      clr_addr <= '0;
    end else begin
      busy <= accept && note_op;
      if (clr) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == AW'(mtd_pkg::NOTE_DEPTH - 1)) clr <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && note_op) begin
      nt_addr  <= {held_e[6:0], run_ch};
      nt_is_on <= (run_status == mtd_pkg::SN_NOTE_ON) && (b[6:0] != 7'd0);
      nt_vel   <= b[6:0];
    end
  end

  mtd_ram #(
    .WIDTH(mtd_pkg::NOTE_W),
    .DEPTH(mtd_pkg::NOTE_DEPTH)
  ) u_note_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr ({held_e[6:0], run_ch}),
    .rdata (nt_rdata)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = nt_addr;
    ram_wdata = '0;
    note_emit = 1'b0;
    note_rec  = '0;
    if (clr) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
    end else if (busy) begin
      if (nt_rdata[mtd_pkg::NOTE_W-1]) begin
        ram_we               = 1'b1;
        note_emit            = 1'b1;
        note_rec.record_kind = mtd_pkg::KIND_NOTE;
        note_rec.channel     = nt_addr[3:0];
        note_rec.key         = nt_addr[AW-1:4];
        note_rec.value       = nt_rdata[TB+6:TB];
        note_rec.start_tick  = nt_rdata[TB-1:0];
        note_rec.stop_tick   = tick;
      end else if (nt_is_on) begin
        ram_we    = 1'b1;
        ram_wdata = {1'b1, nt_vel, tick};
      end
    end
  end

  // output queue, head drives the port
  assign push     = (accept && parse_emit) || note_emit;
  assign push_rec = note_emit ? note_rec : parse_rec;
  assign pop      = rec_out.valid && rec_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_cnt <= '0;
    end else begin
      q_cnt <= q_cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push && pop) begin
      if (q_cnt == 2'd1) begin
        q0 <= push_rec;
      end else begin
        q0 <= q1;
        q1 <= push_rec;
      end
    end else if (push) begin
      if (q_cnt == 2'd0) q0 <= push_rec;
      else               q1 <= push_rec;
    end else if (pop) begin
      q0 <= q1;
    end
  end

  assign rec_out.valid       = (q_cnt != 2'd0);
  assign rec_out.record_kind = q0.record_kind;
  assign rec_out.channel     = q0.channel;
  assign rec_out.key         = q0.key;
  assign rec_out.value       = q0.value;
  assign rec_out.start_tick  = q0.start_tick;
  assign rec_out.stop_tick   = q0.stop_tick;
  assign rec_out.tempo       = q0.tempo;

endmodule
